// File: hw/rtl/ckb_pkg.sv
// shared types and constants for the color keyed sprite blit core
// no dependencies; used by every module of the block
package ckb_pkg;

  localparam int unsigned COORD_BITS = 12;
  // screen coordinate is origin plus counter, one bit wider
  localparam int unsigned SCR_W      = COORD_BITS + 1;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COLOR_W    = 3 * CHAN_W;
  localparam int unsigned ADDR_W     = 26;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned PROD_W     = SCR_W + COORD_BITS;
  localparam int unsigned SUM_W      = PROD_W + 1;
  localparam int unsigned SCALED_W   = SUM_W + BPP_W;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  localparam int unsigned APB_AW     = 5;
  localparam int unsigned APB_DW     = 32;

  localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH  = COORD_BITS'(1024);
  localparam logic [COORD_BITS-1:0] RST_SCREEN_HEIGHT = COORD_BITS'(768);
  localparam logic [BPP_W-1:0]      RST_BPP           = BPP_W'(3);
  localparam logic [COORD_BITS-1:0] RST_IMAGE_WIDTH   = COORD_BITS'(16);
  localparam logic [COORD_BITS-1:0] RST_IMAGE_HEIGHT  = COORD_BITS'(16);

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_BPP           = 3'd2,
    REG_IMAGE_WIDTH   = 3'd3,
    REG_IMAGE_HEIGHT  = 3'd4,
    REG_ORIGIN_X      = 3'd5,
    REG_ORIGIN_Y      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] screen_width;
    logic [COORD_BITS-1:0] screen_height;
    logic [BPP_W-1:0]      bytes_per_pixel;
    logic [COORD_BITS-1:0] image_width;
    logic [COORD_BITS-1:0] image_height;
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
  } cfg_t;

  // one classified pixel as it travels from front to back
  typedef struct packed {
    logic               we;
    logic [SCR_W-1:0]   x;
    logic [SCR_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic               done;
  } blit_item_t;

endpackage

// File: hw/rtl/ckb_front.sv
// front end: takes source pixels, walks the image counters, clips and keys
// depends on ckb_pkg
module ckb_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ckb_pkg::cfg_t           cfg_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [ckb_pkg::CHAN_W-1:0] red_i,
  input  logic [ckb_pkg::CHAN_W-1:0] green_i,
  input  logic [ckb_pkg::CHAN_W-1:0] blue_i,
  output logic                    push_o,
  input  logic                    full_i,
  output ckb_pkg::blit_item_t     item_o
);
  import ckb_pkg::*;

  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic [SCR_W-1:0]      x, y;
  logic                  last_col, last_row, visible, opaque, we, fire;

  assign ready_o = !full_i;
  assign fire    = valid_i && !full_i;
  assign push_o  = fire;

  always_comb begin
    x        = {1'b0, cfg_i.origin_x} + {1'b0, col_q};
    y        = {1'b0, cfg_i.origin_y} + {1'b0, row_q};
    last_col = ({1'b0, col_q} + SCR_W'(1)) >= {1'b0, cfg_i.image_width};
    last_row = ({1'b0, row_q} + SCR_W'(1)) >= {1'b0, cfg_i.image_height};
    visible  = (x < {1'b0, cfg_i.screen_width}) && (y < {1'b0, cfg_i.screen_height});
    // a zero in any channel is the transparency key
    opaque   = (red_i != '0) && (green_i != '0) && (blue_i != '0);
    we       = visible && opaque;

    item_o.we    = we;
    item_o.x     = x;
    item_o.y     = y;
    item_o.color = we ? {red_i, green_i, blue_i} : '0;
    item_o.done  = last_col && last_row;

    col_d = col_q;
    row_d = row_q;
    if (fire) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + COORD_BITS'(1);
      end else begin
        col_d = col_q + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: hw/rtl/ckb_fifo.sv
// short queue of classified pixels between the front and the back end
// depends on ckb_pkg
module ckb_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ckb_pkg::blit_item_t item_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output ckb_pkg::blit_item_t item_o
);
  import ckb_pkg::*;

  blit_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + FIFO_PTR_W'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + FIFO_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (FIFO_PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (FIFO_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/ckb_back.sv
// back end: two stage address pipeline, the second stage being the output register
// depends on ckb_pkg
module ckb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ckb_pkg::cfg_t                 cfg_i,
  input  logic                          valid_i,
  output logic                          pop_o,
  input  ckb_pkg::blit_item_t           item_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic                          we_o,
  output logic [ckb_pkg::ADDR_W-1:0]    addr_o,
  output logic [ckb_pkg::COLOR_W-1:0]   color_o,
  output logic                          done_o
);
  import ckb_pkg::*;

  // stage 1: row product
  logic                  s1_v_q;
  logic [PROD_W-1:0]     s1_prod_q;
  logic [SCR_W-1:0]      s1_x_q;
  logic                  s1_we_q, s1_done_q;
  logic [COLOR_W-1:0]    s1_color_q;
  // stage 2: output register
  logic                  s2_v_q;
  logic [ADDR_W-1:0]     s2_addr_q;
  logic [COLOR_W-1:0]    s2_color_q;
  logic                  s2_we_q, s2_done_q;

  logic                  adv1, adv2;
  logic [SUM_W-1:0]      lin;
  logic [SCALED_W-1:0]   scaled;

  assign adv2  = s1_v_q && (!s2_v_q || ready_i);
  assign adv1  = valid_i && (!s1_v_q || adv2);
  assign pop_o = adv1;

  always_comb begin
    lin    = SUM_W'(s1_prod_q) + SUM_W'(s1_x_q);
    scaled = SCALED_W'(lin) * SCALED_W'(cfg_i.bytes_per_pixel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_q <= 1'b1;
      end else if (adv2) begin
        s1_v_q <= 1'b0;
      end
      if (adv2) begin
        s2_v_q <= 1'b1;
      end else if (ready_i) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_prod_q  <= PROD_W'(item_i.y) * PROD_W'(cfg_i.screen_width);
      s1_x_q     <= item_i.x;
      s1_we_q    <= item_i.we;
      s1_color_q <= item_i.color;
      s1_done_q  <= item_i.done;
    end
    if (adv2) begin
      // address wraps modulo the frame buffer span, zero when not written
      s2_addr_q  <= s1_we_q ? scaled[ADDR_W-1:0] : '0;
      s2_color_q <= s1_color_q;
      s2_we_q    <= s1_we_q;
      s2_done_q  <= s1_done_q;
    end
  end

  assign valid_o = s2_v_q;
  assign we_o    = s2_we_q;
  assign addr_o  = s2_addr_q;
  assign color_o = s2_color_q;
  assign done_o  = s2_done_q;

endmodule

// File: hw/rtl/color_keyed_sprite_blit_core.sv
// Color keyed sprite blit core. Source pixels stream in one per transfer in
// raster order; each yields exactly one result transfer carrying the write
// flag (tuser), frame buffer byte address and packed color (tdata) and the
// end of image mark (tlast). A pixel is written only if it falls inside the
// screen and none of its channels is zero; otherwise address and color are
// zero. The core sustains one pixel per clock while the result side accepts: the
// front end classifies a pixel in the cycle it is taken, a four entry queue
// decouples it from the back end, and the back end computes the address in two
// registered stages (row product, then add and stride multiply), so a result
// is offered once its pixel has passed the queue and both stages. Registers
// sit on the APB port at byte offsets 0x00..0x18 and should only be written
// while the core is idle.
// depends on ckb_pkg, ckb_front, ckb_fifo, ckb_back
module color_keyed_sprite_blit_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // apb configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ckb_pkg::APB_AW-1:0]  paddr,
  input  logic [ckb_pkg::APB_DW-1:0]  pwdata,
  output logic [ckb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // source pixels
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  // frame buffer writes
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [55:0]                 m_axis_tdata,  // byte_address[25:0], color_word[49:26]
  output logic                        m_axis_tuser,  // write_enable
  output logic                        m_axis_tlast   // image_done
);
  import ckb_pkg::*;

  cfg_t               cfg_q, cfg_d;
  reg_idx_e           reg_idx;
  logic               wr_en;

  blit_item_t         front_item, fifo_item;
  logic               push, full, fifo_valid, pop;
  logic               out_we, out_done;
  logic [ADDR_W-1:0]  out_addr;
  logic [COLOR_W-1:0] out_color;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (reg_idx)
      REG_SCREEN_WIDTH: begin
        prdata = APB_DW'(cfg_q.screen_width);
        if (wr_en) cfg_d.screen_width = pwdata[COORD_BITS-1:0];
      end
      REG_SCREEN_HEIGHT: begin
        prdata = APB_DW'(cfg_q.screen_height);
        if (wr_en) cfg_d.screen_height = pwdata[COORD_BITS-1:0];
      end
      REG_BPP: begin
        prdata = APB_DW'(cfg_q.bytes_per_pixel);
        if (wr_en) cfg_d.bytes_per_pixel = pwdata[BPP_W-1:0];
      end
      REG_IMAGE_WIDTH: begin
        prdata = APB_DW'(cfg_q.image_width);
        if (wr_en) cfg_d.image_width = pwdata[COORD_BITS-1:0];
      end
      REG_IMAGE_HEIGHT: begin
        prdata = APB_DW'(cfg_q.image_height);
        if (wr_en) cfg_d.image_height = pwdata[COORD_BITS-1:0];
      end
      REG_ORIGIN_X: begin
        prdata = APB_DW'(cfg_q.origin_x);
        if (wr_en) cfg_d.origin_x = pwdata[COORD_BITS-1:0];
      end
      REG_ORIGIN_Y: begin
        prdata = APB_DW'(cfg_q.origin_y);
        if (wr_en) cfg_d.origin_y = pwdata[COORD_BITS-1:0];
      end
      default: begin
        // unmapped offset: reads zero, writes ignored
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width    <= RST_SCREEN_WIDTH;
      cfg_q.screen_height   <= RST_SCREEN_HEIGHT;
      cfg_q.bytes_per_pixel <= RST_BPP;
      cfg_q.image_width     <= RST_IMAGE_WIDTH;
      cfg_q.image_height    <= RST_IMAGE_HEIGHT;
      cfg_q.origin_x        <= '0;
      cfg_q.origin_y        <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ckb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .push_o  (push),
    .full_i  (full),
    .item_o  (front_item)
  );

  ckb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .item_o  (fifo_item)
  );

  ckb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (fifo_valid),
    .pop_o   (pop),
    .item_i  (fifo_item),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .we_o    (out_we),
    .addr_o  (out_addr),
    .color_o (out_color),
    .done_o  (out_done)
  );

  assign m_axis_tdata = {6'b0, out_color, out_addr};
  assign m_axis_tuser = out_we;
  assign m_axis_tlast = out_done;

endmodule

// File: verif/blit_write_checker.sv
// scoreboard for the color keyed sprite blit core: follows the apb register
// writes and the pixel stream, predicts every frame buffer write and compares
// it field by field with what the core emits. depends on ckb_pkg
module blit_write_checker
  import ckb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic                pready,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [55:0]         m_axis_tdata,  // byte_address[25:0], color_word[49:26]
  input  logic                m_axis_tuser,  // write_enable
  input  logic                m_axis_tlast,  // image_done
  output int unsigned         mismatch_count_o,
  output int unsigned         writes_pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               done;
  } fb_write_t;

  cfg_t                  geom;
  logic [COORD_BITS-1:0] col_q;
  logic [COORD_BITS-1:0] row_q;
  fb_write_t             fb_writes_due[$];
  fb_write_t             oldest;
  int unsigned           mismatches;

  // classify one source pixel and step the raster counters
  function automatic fb_write_t blit_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [SCR_W-1:0] x;
    logic [SCR_W-1:0] y;
    logic             last_col;
    logic             last_row;
    longint unsigned  lin;
    fb_write_t        w;
    x        = SCR_W'(geom.origin_x) + SCR_W'(col_q);
    y        = SCR_W'(geom.origin_y) + SCR_W'(row_q);
    last_col = (SCR_W'(col_q) + SCR_W'(1)) >= SCR_W'(geom.image_width);
    last_row = (SCR_W'(row_q) + SCR_W'(1)) >= SCR_W'(geom.image_height);
    w.done   = last_col && last_row;
    w.we     = (x < SCR_W'(geom.screen_width)) && (y < SCR_W'(geom.screen_height)) &&
               (r != 8'd0) && (g != 8'd0) && (b != 8'd0);
    w.addr   = '0;
    w.color  = '0;
    if (w.we) begin
      lin = (64'(y) * 64'(geom.screen_width) + 64'(x)) * 64'(geom.bytes_per_pixel);
      w.addr  = ADDR_W'(lin);
      w.color = {r, g, b};
    end
    if (last_col) begin
      col_q = '0;
      row_q = last_row ? '0 : row_q + COORD_BITS'(1);
    end else begin
      col_q = col_q + COORD_BITS'(1);
    end
    return w;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom.screen_width    = RST_SCREEN_WIDTH;
      geom.screen_height   = RST_SCREEN_HEIGHT;
      geom.bytes_per_pixel = RST_BPP;
      geom.image_width     = RST_IMAGE_WIDTH;
      geom.image_height    = RST_IMAGE_HEIGHT;
      geom.origin_x        = '0;
      geom.origin_y        = '0;
      col_q                = '0;
      row_q                = '0;
      mismatches           = 0;
      fb_writes_due.delete();
      mismatch_count_o     <= 0;
      writes_pending_o     <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_SCREEN_WIDTH:  geom.screen_width    = pwdata[COORD_BITS-1:0];
          REG_SCREEN_HEIGHT: geom.screen_height   = pwdata[COORD_BITS-1:0];
          REG_BPP:           geom.bytes_per_pixel = pwdata[BPP_W-1:0];
          REG_IMAGE_WIDTH:   geom.image_width     = pwdata[COORD_BITS-1:0];
          REG_IMAGE_HEIGHT:  geom.image_height    = pwdata[COORD_BITS-1:0];
          REG_ORIGIN_X:      geom.origin_x        = pwdata[COORD_BITS-1:0];
          REG_ORIGIN_Y:      geom.origin_y        = pwdata[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fb_writes_due.push_back(blit_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                           s_axis_tdata[23:16]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (fb_writes_due.size() == 0) begin
          mismatches++;
          $display("%0t: write transfer with none pending, expected none actual %h/%h/%b/%b",
                   $realtime, m_axis_tdata[25:0], m_axis_tdata[49:26], m_axis_tuser,
                   m_axis_tlast);
        end else begin
          oldest = fb_writes_due.pop_front();
          check_field("write_enable", 32'(oldest.we), 32'(m_axis_tuser));
          check_field("byte_address", 32'(oldest.addr), 32'(m_axis_tdata[25:0]));
          check_field("color_word", 32'(oldest.color), 32'(m_axis_tdata[49:26]));
          check_field("image_done", 32'(oldest.done), 32'(m_axis_tlast));
        end
      end
      mismatch_count_o <= mismatches;
      writes_pending_o <= fb_writes_due.size();
    end
  end

endmodule

// File: verif/tb_color_keyed_sprite_blit_core.sv
// top of the color keyed sprite blit testbench: clock, reset, apb setup,
// pixel stimulus and result backpressure; checking lives in blit_write_checker
// depends on ckb_pkg, blit_write_checker and color_keyed_sprite_blit_core
module tb_color_keyed_sprite_blit_core;

  import ckb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned RX_HOLD      = 64;
  localparam int unsigned PHASE_PIXELS = 400;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [55:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  int unsigned mismatches;
  int unsigned writes_pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;
  bit          rx_hold_req;

  color_keyed_sprite_blit_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  blit_write_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatches),
    .writes_pending_o (writes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random backpressure, or one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering pixels and let every predicted write drain out
  task automatic drain_writes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (writes_pending != 0) @(posedge clk_i);
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned bpp,
                              int unsigned iw, int unsigned ih,
                              int unsigned ox, int unsigned oy);
    drain_writes();
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, sh);
    write_reg(REG_BPP, bpp);
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_IMAGE_HEIGHT, ih);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
  endtask

  // valid is only lowered when a gap actually follows
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random_pixel();
    logic [7:0] ch[3];
    foreach (ch[i]) ch[i] = 8'($urandom_range(1, 255));
    case ($urandom_range(9))
      0, 1:    ch[$urandom_range(2)] = 8'd0;
      2:       foreach (ch[i]) ch[i] = 8'($urandom_range(255));
      default: ;
    endcase
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  function automatic int unsigned pick_extent(int unsigned hi_common);
    case ($urandom_range(19))
      0:       return 0;
      1:       return 4095;
      2, 3:    return $urandom_range(1, 4095);
      default: return $urandom_range(1, hi_common);
    endcase
  endfunction

  function automatic int unsigned pick_origin();
    case ($urandom_range(9))
      0:       return 4095;
      1:       return $urandom_range(4095);
      default: return $urandom_range(70);
    endcase
  endfunction

  task automatic random_geometry();
    int unsigned bpp;
    bpp = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
    set_geometry(pick_extent(64), pick_extent(64), bpp, pick_extent(8), pick_extent(8),
                 pick_origin(), pick_origin());
  endtask

  initial begin
    int unsigned left;
    int unsigned burst;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    rx_hold_req   = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: transparency key on each channel, full and minimal colors
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h01, 8'h01, 8'h01);
    send_pixel(8'h80, 8'h40, 8'h20);
    // rewrite mid image: counters beyond the new limits wrap, clipping on both axes
    set_geometry(4, 3, 4, 3, 2, 2, 2);
    repeat (8) send_pixel(8'($urandom_range(1, 255)), 8'h7F, 8'hFE);
    // largest screen and origin, odd stride, zero image size acts as one
    set_geometry(4095, 4095, 7, 0, 0, 4094, 4094);
    send_pixel(8'hAA, 8'h55, 8'hC3);
    send_pixel(8'h3C, 8'h99, 8'h0F);
    drain_writes();
    write_reg(REG_ORIGIN_X, 4095);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    // zero screen width clips everything, zero stride
    set_geometry(0, 5, 0, 2, 1, 0, 0);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    set_geometry(5, 5, 0, 2, 1, 1, 1);
    send_pixel(8'h12, 8'h34, 8'h56);
    send_pixel(8'hED, 8'hCB, 8'hA9);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 83 : 0;
      recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 18 : 0;
      left = PHASE_PIXELS;
      while (left > 0) begin
        random_geometry();
        burst = $urandom_range(5, 60);
        if (burst > left) burst = left;
        if (phase == 2 && left == PHASE_PIXELS) begin
          // enough pixels behind the hold-off to fill the core
          rx_hold_req = 1'b1;
          burst = 40;
        end
        repeat (burst) send_random_pixel();
        left -= burst;
      end
    end

    drain_writes();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && writes_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
